// File: sv/stts_pkg.sv
package stts_pkg;

  localparam int PosBits  = 24;
  localparam int LineBits = 20;
  localparam int KwChars  = 8;
  localparam int WlenBits = $clog2(KwChars + 2);
  localparam int NumKw    = 21;
  localparam int MaxRes   = 4;

  localparam logic [5:0] K_LPAREN   = 6'd0;
  localparam logic [5:0] K_RPAREN   = 6'd1;
  localparam logic [5:0] K_LBRACE   = 6'd2;
  localparam logic [5:0] K_RBRACE   = 6'd3;
  localparam logic [5:0] K_COMMA    = 6'd4;
  localparam logic [5:0] K_LBRACK   = 6'd5;
  localparam logic [5:0] K_RBRACK   = 6'd6;
  localparam logic [5:0] K_COLON    = 6'd7;
  localparam logic [5:0] K_DOT      = 6'd8;
  localparam logic [5:0] K_DOT2     = 6'd9;
  localparam logic [5:0] K_DOT3     = 6'd10;
  localparam logic [5:0] K_MINUS    = 6'd11;
  localparam logic [5:0] K_PLUS     = 6'd12;
  localparam logic [5:0] K_SEMI     = 6'd13;
  localparam logic [5:0] K_STAR     = 6'd14;
  localparam logic [5:0] K_TILDE_EQ = 6'd15;
  localparam logic [5:0] K_EQ       = 6'd16;
  localparam logic [5:0] K_EQEQ     = 6'd17;
  localparam logic [5:0] K_LT       = 6'd18;
  localparam logic [5:0] K_LE       = 6'd19;
  localparam logic [5:0] K_GT       = 6'd20;
  localparam logic [5:0] K_GE       = 6'd21;
  localparam logic [5:0] K_SLASH    = 6'd22;
  localparam logic [5:0] K_PERCENT  = 6'd23;
  localparam logic [5:0] K_CARET    = 6'd24;
  localparam logic [5:0] K_HASH     = 6'd25;
  localparam logic [5:0] K_IDENT    = 6'd26;
  localparam logic [5:0] K_STRING   = 6'd27;
  localparam logic [5:0] K_NUMBER   = 6'd28;
  localparam logic [5:0] K_KEYWORD0 = 6'd29;
  localparam logic [5:0] K_END      = 6'd50;

  localparam logic [2:0] E_NONE      = 3'd0;
  localparam logic [2:0] E_BAD_CHAR  = 3'd1;
  localparam logic [2:0] E_TILDE     = 3'd2;
  localparam logic [2:0] E_OPEN_STR  = 3'd3;
  localparam logic [2:0] E_OPEN_LSTR = 3'd4;
  localparam logic [2:0] E_OPEN_BCMT = 3'd5;

  localparam logic [KwChars*8-1:0] KW_TXT [NumKw] = '{
    {"and", 40'h0}, {"break", 24'h0}, {"do", 48'h0}, {"else", 32'h0},
    {"elseif", 16'h0}, {"end", 40'h0}, {"false", 24'h0}, {"for", 40'h0},
    {"function"}, {"if", 48'h0}, {"in", 48'h0}, {"local", 24'h0},
    {"nil", 40'h0}, {"not", 40'h0}, {"or", 48'h0}, {"repeat", 16'h0},
    {"return", 16'h0}, {"then", 32'h0}, {"true", 32'h0}, {"until", 24'h0},
    {"while", 24'h0}
  };

  localparam logic [WlenBits-1:0] KW_LEN [NumKw] = '{
    WlenBits'(3), WlenBits'(5), WlenBits'(2), WlenBits'(4), WlenBits'(6),
    WlenBits'(3), WlenBits'(5), WlenBits'(3), WlenBits'(8), WlenBits'(2),
    WlenBits'(2), WlenBits'(5), WlenBits'(3), WlenBits'(3), WlenBits'(2),
    WlenBits'(6), WlenBits'(6), WlenBits'(4), WlenBits'(4), WlenBits'(5),
    WlenBits'(5)
  };

  typedef enum logic [19:0] {
    M_IDLE      = 20'h00001,
    M_IDENT     = 20'h00002,
    M_NUM       = 20'h00004,
    M_NUM_DOT   = 20'h00008,
    M_FRAC      = 20'h00010,
    M_MINUS     = 20'h00020,
    M_DASH2     = 20'h00040,
    M_DASH2_BR  = 20'h00080,
    M_LINE_CMT  = 20'h00100,
    M_BLOCK_CMT = 20'h00200,
    M_LBR       = 20'h00400,
    M_LONG_STR  = 20'h00800,
    M_DOT1      = 20'h01000,
    M_DOT2      = 20'h02000,
    M_EQ        = 20'h04000,
    M_LT        = 20'h08000,
    M_GT        = 20'h10000,
    M_TILDE     = 20'h20000,
    M_STR       = 20'h40000,
    M_ERR       = 20'h80000
  } mode_t;

  typedef struct packed {
    mode_t                       mode;
    logic [PosBits-1:0]          tstart;
    logic [PosBits-1:0]          pos;
    logic [LineBits-1:0]         line;
    logic [KwChars-1:0][7:0]     wbuf;
    logic [WlenBits-1:0]         wlen;
    logic                        qdbl;
    logic                        cbr;
  } scan_state_t;

  // stop is one past the last byte; it may exceed the saturated position
  typedef struct packed {
    logic [5:0]          kind;
    logic [PosBits-1:0]  start;
    logic [PosBits:0]    stop;
    logic [LineBits-1:0] line;
    logic [2:0]          err;
  } tok_rec_t;

  typedef struct packed {
    logic [2:0]              cnt;
    tok_rec_t [MaxRes-1:0]   rec;
  } tok_bundle_t;

  function automatic logic [5:0] word_kind(input logic [KwChars-1:0][7:0] wb,
                                           input logic [WlenBits-1:0] len);
    logic [5:0] k;
    logic       hit;
    k = K_IDENT;
    for (int i = 0; i < NumKw; i++) begin
      hit = (len == KW_LEN[i]);
      for (int j = 0; j < KwChars; j++) begin
        if (j < int'(len) && wb[j] != KW_TXT[i][KwChars*8-1-8*j -: 8]) hit = 1'b0;
      end
      if (hit && k == K_IDENT) k = 6'(int'(K_KEYWORD0) + i);
    end
    return k;
  endfunction

  function automatic tok_bundle_t add_tok(input tok_bundle_t b, input logic [5:0] kind,
                                          input logic [PosBits-1:0] start,
                                          input logic [PosBits:0] stop,
                                          input logic [LineBits-1:0] line,
                                          input logic [2:0] err);
    tok_bundle_t r;
    r = b;
    if (b.cnt < 3'(MaxRes)) begin
      r.rec[b.cnt[1:0]] = '{kind: kind, start: start, stop: stop, line: line, err: err};
      r.cnt = b.cnt + 3'd1;
    end
    return r;
  endfunction

endpackage

// File: sv/stts_in_if.sv
interface stts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       has_byte;
  logic       end_of_source;

  modport source(output valid, text_byte, has_byte, end_of_source, input ready);
  modport sink(input valid, text_byte, has_byte, end_of_source, output ready);
endinterface

// File: sv/stts_out_if.sv
interface stts_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  token_kind;
  logic [23:0] start_offset;
  logic [23:0] lexeme_length;
  logic [19:0] line_number;
  logic [2:0]  error_code;
  logic        last_of_run;

  modport source(output valid, token_kind, start_offset, lexeme_length, line_number,
                 error_code, last_of_run, input ready);
  modport sink(input valid, token_kind, start_offset, lexeme_length, line_number,
               error_code, last_of_run, output ready);
endinterface

// File: sv/script_token_scanner.sv
// Streaming tokenizer for script source text.
// in_ch carries one source byte per transfer (has_byte) and an end-of-source
// flag; an item with has_byte low and end_of_source high only closes the source.
// out_ch carries one token per transfer: kind, start offset, length, line and
// error code; last_of_run marks the final token caused by one input item.
// An input item is scanned in the cycle it is taken; its tokens (zero to four)
// land together in a two-deep token-group queue and leave one per cycle while
// the receiver is ready; tokens reach out_ch only from that registered queue.
// Throughput is one input item per cycle as long as each item yields at most
// one token and the receiver keeps up; an item yielding several tokens holds
// the output until all of them have left. in_ch.ready drops only while both queue slots are full.
// When the receiver stalls, the current token holds and input keeps flowing
// until the queue fills. End of source flushes the pending token, emits the
// end token and rewinds offsets and lines for a new source.
// Reset (synchronous, active low) empties the queue and returns the scanner to
// the between-tokens state at offset 0, line 1.
module script_token_scanner (
  input  logic       clk,
  input  logic       rst_n,
  stts_in_if.sink    in_ch,
  stts_out_if.source out_ch
);

  stts_pkg::tok_bundle_t bundle;
  logic                  acc;
  logic                  space;

  assign in_ch.ready = space;
  assign acc         = in_ch.valid && space;

  stts_step u_step (
    .clk           (clk),
    .rst_n         (rst_n),
    .acc           (acc),
    .text_byte     (in_ch.text_byte),
    .has_byte      (in_ch.has_byte),
    .end_of_source (in_ch.end_of_source),
    .bundle        (bundle)
  );

  stts_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (acc && bundle.cnt != 3'd0),
    .push_data (bundle),
    .space     (space),
    .out_ch    (out_ch)
  );

endmodule

// File: sv/stts_step.sv
module stts_step (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  acc,
  input  logic [7:0]            text_byte,
  input  logic                  has_byte,
  input  logic                  end_of_source,
  output stts_pkg::tok_bundle_t bundle
);

  localparam logic [stts_pkg::PosBits-1:0]  PosMax  = '1;
  localparam logic [stts_pkg::LineBits-1:0] LineMax = '1;

  stts_pkg::scan_state_t st_r, st_nxt, st_rst;

  always_comb begin
    st_rst        = '0;
    st_rst.mode   = stts_pkg::M_IDLE;
    st_rst.line   = stts_pkg::LineBits'(1);
  end

  always_comb begin
    stts_pkg::scan_state_t       s;
    stts_pkg::tok_bundle_t       b;
    logic [7:0]                  c;
    logic                        redo;
    logic                        digit, alpha;
    logic [stts_pkg::PosBits:0]  p0, p1, pm1, q0, qm1;
    logic [stts_pkg::PosBits-1:0] posf;
    logic [5:0]                  kw_old, one;

    s      = st_r;
    b      = '0;
    c      = text_byte;
    digit  = (c >= "0") && (c <= "9");
    alpha  = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
    p0     = {1'b0, st_r.pos};
    p1     = p0 + 1'b1;
    pm1    = p0 - 1'b1;
    kw_old = stts_pkg::word_kind(st_r.wbuf, st_r.wlen);
    redo   = has_byte;
    one    = stts_pkg::K_EQ;

    // a byte can close a token and still need another look in the new mode
    for (int k = 0; k < 3; k++) begin
      if (redo) begin
        redo = 1'b0;
        unique case (s.mode)
          stts_pkg::M_IDLE: begin
            unique case (c)
              "(": b = stts_pkg::add_tok(b, stts_pkg::K_LPAREN, s.pos, p1, s.line, stts_pkg::E_NONE);
              ")": b = stts_pkg::add_tok(b, stts_pkg::K_RPAREN, s.pos, p1, s.line, stts_pkg::E_NONE);
              "{": b = stts_pkg::add_tok(b, stts_pkg::K_LBRACE, s.pos, p1, s.line, stts_pkg::E_NONE);
              "}": b = stts_pkg::add_tok(b, stts_pkg::K_RBRACE, s.pos, p1, s.line, stts_pkg::E_NONE);
              ",": b = stts_pkg::add_tok(b, stts_pkg::K_COMMA, s.pos, p1, s.line, stts_pkg::E_NONE);
              "]": b = stts_pkg::add_tok(b, stts_pkg::K_RBRACK, s.pos, p1, s.line, stts_pkg::E_NONE);
              ":": b = stts_pkg::add_tok(b, stts_pkg::K_COLON, s.pos, p1, s.line, stts_pkg::E_NONE);
              "+": b = stts_pkg::add_tok(b, stts_pkg::K_PLUS, s.pos, p1, s.line, stts_pkg::E_NONE);
              ";": b = stts_pkg::add_tok(b, stts_pkg::K_SEMI, s.pos, p1, s.line, stts_pkg::E_NONE);
              "*": b = stts_pkg::add_tok(b, stts_pkg::K_STAR, s.pos, p1, s.line, stts_pkg::E_NONE);
              "/": b = stts_pkg::add_tok(b, stts_pkg::K_SLASH, s.pos, p1, s.line, stts_pkg::E_NONE);
              "%": b = stts_pkg::add_tok(b, stts_pkg::K_PERCENT, s.pos, p1, s.line, stts_pkg::E_NONE);
              "^": b = stts_pkg::add_tok(b, stts_pkg::K_CARET, s.pos, p1, s.line, stts_pkg::E_NONE);
              "#": b = stts_pkg::add_tok(b, stts_pkg::K_HASH, s.pos, p1, s.line, stts_pkg::E_NONE);
              "[": begin s.mode = stts_pkg::M_LBR;   s.tstart = s.pos; end
              ".": begin s.mode = stts_pkg::M_DOT1;  s.tstart = s.pos; end
              "-": begin s.mode = stts_pkg::M_MINUS; s.tstart = s.pos; end
              "=": begin s.mode = stts_pkg::M_EQ;    s.tstart = s.pos; end
              "<": begin s.mode = stts_pkg::M_LT;    s.tstart = s.pos; end
              ">": begin s.mode = stts_pkg::M_GT;    s.tstart = s.pos; end
              "~": begin s.mode = stts_pkg::M_TILDE; s.tstart = s.pos; end
              " ", 8'h09, 8'h0d: ;
              8'h0a: if (s.line < LineMax) s.line = s.line + 1'b1;
              "\"", "'": begin
                s.qdbl   = (c == "\"");
                s.mode   = stts_pkg::M_STR;
                s.tstart = s.pos;
              end
              default: begin
                if (digit) begin
                  s.mode   = stts_pkg::M_NUM;
                  s.tstart = s.pos;
                end else if (alpha) begin
                  s.mode    = stts_pkg::M_IDENT;
                  s.tstart  = s.pos;
                  s.wbuf[0] = c;
                  s.wlen    = stts_pkg::WlenBits'(1);
                end else begin
                  b = stts_pkg::add_tok(b, 6'd0, s.pos, p1, s.line, stts_pkg::E_BAD_CHAR);
                  s.mode = stts_pkg::M_ERR;
                end
              end
            endcase
          end
          stts_pkg::M_IDENT: begin
            if (alpha || digit) begin
              if (s.wlen < stts_pkg::WlenBits'(stts_pkg::KwChars))
                s.wbuf[s.wlen[$clog2(stts_pkg::KwChars)-1:0]] = c;
              if (s.wlen <= stts_pkg::WlenBits'(stts_pkg::KwChars)) s.wlen = s.wlen + 1'b1;
            end else begin
              b = stts_pkg::add_tok(b, kw_old, s.tstart, p0, s.line, stts_pkg::E_NONE);
              s.mode = stts_pkg::M_IDLE;
              redo   = 1'b1;
            end
          end
          stts_pkg::M_NUM, stts_pkg::M_FRAC: begin
            if (digit) begin
            end else if (c == "." && s.mode == stts_pkg::M_NUM) begin
              s.mode = stts_pkg::M_NUM_DOT;
            end else begin
              b = stts_pkg::add_tok(b, stts_pkg::K_NUMBER, s.tstart, p0, s.line, stts_pkg::E_NONE);
              s.mode = stts_pkg::M_IDLE;
              redo   = 1'b1;
            end
          end
          stts_pkg::M_NUM_DOT: begin
            if (digit) begin
              s.mode = stts_pkg::M_FRAC;
            end else begin
              b = stts_pkg::add_tok(b, stts_pkg::K_NUMBER, s.tstart, pm1, s.line, stts_pkg::E_NONE);
              s.mode   = stts_pkg::M_DOT1;
              s.tstart = pm1[stts_pkg::PosBits-1:0];
              redo     = 1'b1;
            end
          end
          stts_pkg::M_MINUS: begin
            if (c == "-") begin
              s.mode = stts_pkg::M_DASH2;
            end else begin
              b = stts_pkg::add_tok(b, stts_pkg::K_MINUS, s.tstart, p0, s.line, stts_pkg::E_NONE);
              s.mode = stts_pkg::M_IDLE;
              redo   = 1'b1;
            end
          end
          stts_pkg::M_DASH2: begin
            if (c == "[") s.mode = stts_pkg::M_DASH2_BR;
            else begin s.mode = stts_pkg::M_LINE_CMT; redo = 1'b1; end
          end
          stts_pkg::M_DASH2_BR: begin
            if (c == "[") begin
              s.mode = stts_pkg::M_BLOCK_CMT;
              s.cbr  = 1'b0;
            end else begin
              s.mode = stts_pkg::M_LINE_CMT;
              redo   = 1'b1;
            end
          end
          stts_pkg::M_LINE_CMT: begin
            if (c == 8'h0a) begin s.mode = stts_pkg::M_IDLE; redo = 1'b1; end
          end
          stts_pkg::M_BLOCK_CMT, stts_pkg::M_LONG_STR: begin
            if (c == "]") begin
              if (s.cbr) begin
                s.cbr = 1'b0;
                if (s.mode == stts_pkg::M_LONG_STR)
                  b = stts_pkg::add_tok(b, stts_pkg::K_STRING, s.tstart, p1, s.line,
                                        stts_pkg::E_NONE);
                s.mode = stts_pkg::M_IDLE;
              end else begin
                s.cbr = 1'b1;
              end
            end else begin
              s.cbr = 1'b0;
              if (c == 8'h0a && s.line < LineMax) s.line = s.line + 1'b1;
            end
          end
          stts_pkg::M_LBR: begin
            if (c == "[") begin
              s.mode = stts_pkg::M_LONG_STR;
              s.cbr  = 1'b0;
            end else begin
              b = stts_pkg::add_tok(b, stts_pkg::K_LBRACK, s.tstart, p0, s.line, stts_pkg::E_NONE);
              s.mode = stts_pkg::M_IDLE;
              redo   = 1'b1;
            end
          end
          stts_pkg::M_DOT1: begin
            if (c == ".") begin
              s.mode = stts_pkg::M_DOT2;
            end else begin
              b = stts_pkg::add_tok(b, stts_pkg::K_DOT, s.tstart, p0, s.line, stts_pkg::E_NONE);
              s.mode = stts_pkg::M_IDLE;
              redo   = 1'b1;
            end
          end
          stts_pkg::M_DOT2: begin
            if (c == ".") begin
              b = stts_pkg::add_tok(b, stts_pkg::K_DOT3, s.tstart, p1, s.line, stts_pkg::E_NONE);
              s.mode = stts_pkg::M_IDLE;
            end else begin
              b = stts_pkg::add_tok(b, stts_pkg::K_DOT2, s.tstart, p0, s.line, stts_pkg::E_NONE);
              s.mode = stts_pkg::M_IDLE;
              redo   = 1'b1;
            end
          end
          stts_pkg::M_EQ, stts_pkg::M_LT, stts_pkg::M_GT: begin
            one = (s.mode == stts_pkg::M_EQ) ? stts_pkg::K_EQ :
                  (s.mode == stts_pkg::M_LT) ? stts_pkg::K_LT : stts_pkg::K_GT;
            if (c == "=") begin
              b = stts_pkg::add_tok(b, one + 6'd1, s.tstart, p1, s.line, stts_pkg::E_NONE);
              s.mode = stts_pkg::M_IDLE;
            end else begin
              b = stts_pkg::add_tok(b, one, s.tstart, p0, s.line, stts_pkg::E_NONE);
              s.mode = stts_pkg::M_IDLE;
              redo   = 1'b1;
            end
          end
          stts_pkg::M_TILDE: begin
            if (c == "=") begin
              b = stts_pkg::add_tok(b, stts_pkg::K_TILDE_EQ, s.tstart, p1, s.line,
                                    stts_pkg::E_NONE);
              s.mode = stts_pkg::M_IDLE;
            end else begin
              b = stts_pkg::add_tok(b, 6'd0, s.tstart, p0, s.line, stts_pkg::E_TILDE);
              s.mode = stts_pkg::M_ERR;
            end
          end
          stts_pkg::M_STR: begin
            if (c == (s.qdbl ? "\"" : "'")) begin
              b = stts_pkg::add_tok(b, stts_pkg::K_STRING, s.tstart, p1, s.line,
                                    stts_pkg::E_NONE);
              s.mode = stts_pkg::M_IDLE;
            end else if (c == 8'h0a && s.line < LineMax) begin
              s.line = s.line + 1'b1;
            end
          end
          default: ;
        endcase
      end
    end

    posf = st_r.pos;
    if (has_byte && st_r.pos < PosMax) posf = st_r.pos + 1'b1;
    s.pos = posf;
    q0  = {1'b0, posf};
    qm1 = q0 - 1'b1;

    if (end_of_source) begin
      unique case (s.mode)
        stts_pkg::M_IDENT:
          b = stts_pkg::add_tok(b, stts_pkg::word_kind(s.wbuf, s.wlen), s.tstart, q0, s.line,
                                stts_pkg::E_NONE);
        stts_pkg::M_NUM, stts_pkg::M_FRAC:
          b = stts_pkg::add_tok(b, stts_pkg::K_NUMBER, s.tstart, q0, s.line, stts_pkg::E_NONE);
        stts_pkg::M_NUM_DOT: begin
          b = stts_pkg::add_tok(b, stts_pkg::K_NUMBER, s.tstart, qm1, s.line, stts_pkg::E_NONE);
          b = stts_pkg::add_tok(b, stts_pkg::K_DOT, qm1[stts_pkg::PosBits-1:0], q0, s.line,
                                stts_pkg::E_NONE);
        end
        stts_pkg::M_MINUS:
          b = stts_pkg::add_tok(b, stts_pkg::K_MINUS, s.tstart, q0, s.line, stts_pkg::E_NONE);
        stts_pkg::M_LBR:
          b = stts_pkg::add_tok(b, stts_pkg::K_LBRACK, s.tstart, q0, s.line, stts_pkg::E_NONE);
        stts_pkg::M_DOT1:
          b = stts_pkg::add_tok(b, stts_pkg::K_DOT, s.tstart, q0, s.line, stts_pkg::E_NONE);
        stts_pkg::M_DOT2:
          b = stts_pkg::add_tok(b, stts_pkg::K_DOT2, s.tstart, q0, s.line, stts_pkg::E_NONE);
        stts_pkg::M_EQ:
          b = stts_pkg::add_tok(b, stts_pkg::K_EQ, s.tstart, q0, s.line, stts_pkg::E_NONE);
        stts_pkg::M_LT:
          b = stts_pkg::add_tok(b, stts_pkg::K_LT, s.tstart, q0, s.line, stts_pkg::E_NONE);
        stts_pkg::M_GT:
          b = stts_pkg::add_tok(b, stts_pkg::K_GT, s.tstart, q0, s.line, stts_pkg::E_NONE);
        stts_pkg::M_TILDE:
          b = stts_pkg::add_tok(b, 6'd0, s.tstart, q0, s.line, stts_pkg::E_TILDE);
        stts_pkg::M_STR:
          b = stts_pkg::add_tok(b, 6'd0, s.tstart, q0, s.line, stts_pkg::E_OPEN_STR);
        stts_pkg::M_LONG_STR:
          b = stts_pkg::add_tok(b, 6'd0, s.tstart, q0, s.line, stts_pkg::E_OPEN_LSTR);
        stts_pkg::M_BLOCK_CMT:
          b = stts_pkg::add_tok(b, 6'd0, s.tstart, q0, s.line, stts_pkg::E_OPEN_BCMT);
        default: ;
      endcase
      b = stts_pkg::add_tok(b, stts_pkg::K_END, posf, q0, s.line, stts_pkg::E_NONE);
      s = st_rst;
    end

    st_nxt = s;
    bundle = b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= st_rst;
    end else if (acc) begin
      st_r <= st_nxt;
    end
  end

endmodule

// File: sv/stts_outq.sv
module stts_outq (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  stts_pkg::tok_bundle_t push_data,
  output logic                  space,
  stts_out_if.source            out_ch
);

  stts_pkg::tok_bundle_t q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic [1:0] idx_r, idx_nxt;

  stts_pkg::tok_bundle_t head;
  stts_pkg::tok_rec_t    rec;
  logic                  take, last, pop;
  logic [stts_pkg::PosBits:0] len;

  assign head  = q_r[rp_r];
  assign rec   = head.rec[idx_r];
  assign last  = ({1'b0, idx_r} == head.cnt - 3'd1);
  assign take  = out_ch.valid && out_ch.ready;
  assign pop   = take && last;
  assign space = (cnt_r != 2'd2);

  // stop can run one past the saturated start; empty span when it is behind
  assign len = (rec.stop >= {1'b0, rec.start}) ? rec.stop - {1'b0, rec.start} : '0;

  assign out_ch.valid         = (cnt_r != 2'd0);
  assign out_ch.token_kind    = rec.kind;
  assign out_ch.start_offset  = rec.start;
  assign out_ch.lexeme_length = len[stts_pkg::PosBits-1:0];
  assign out_ch.line_number   = rec.line;
  assign out_ch.error_code    = rec.err;
  assign out_ch.last_of_run   = last;

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
    idx_nxt = idx_r;
    if (take) idx_nxt = last ? 2'd0 : idx_r + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
      idx_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= push_data;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("bundle queue overflow");
  a_no_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (head.cnt != 3'd0 && {1'b0, idx_r} < head.cnt))
    else $error("head bundle index out of range");
  a_push_space: assert property (@(posedge clk) disable iff (!rst_n) push |-> space)
    else $error("push into full queue");
  a_idx_clear: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> idx_r == 2'd0)
    else $error("result index not cleared after bundle");

endmodule
